// ----- src/psef_pkg.sv -----
`timescale 1ns / 1ps
// Package for the per-source event flag table.
// Holds field widths, configuration register indexes, their reset values and the connection state codes.
// No dependencies.
package psef_pkg;

  // Field widths of the flow record and the result
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned PORT_W  = 16;
  localparam int unsigned BYTES_W = 32;
  localparam int unsigned STATE_W = 2;
  localparam int unsigned OUTIDX_W = 6;
  localparam int unsigned TOTAL_W = 16;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_LOGIN_PORT_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCAN_PORT_MIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCAN_BYTES_MIN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FLAG_THRESHOLD = 2'd3;

  localparam logic [PORT_W-1:0]  RST_LOGIN_PORT_MIN = 16'd10000;
  localparam logic [PORT_W-1:0]  RST_SCAN_PORT_MIN  = 16'd1024;
  localparam logic [BYTES_W-1:0] RST_SCAN_BYTES_MIN = 32'd10000;
  localparam logic [TOTAL_W-1:0] RST_FLAG_THRESHOLD = 16'd2;

  // Connection state codes
  localparam logic [STATE_W-1:0] CONN_ESTABLISHED = 2'd0;
  localparam logic [STATE_W-1:0] CONN_RESET       = 2'd1;
  localparam logic [STATE_W-1:0] CONN_INTERRUPTED = 2'd2;

endpackage

// ----- src/per_source_event_flag_table_unit.sv -----
`timescale 1ns / 1ps
// Per-source event flag table: source lookup/insert and per-source counters.
// Depends on psef_pkg.
//
// Usage:
//   Input channel: drive the flow record fields and raise start_i; the
//   transaction is taken at a clock edge with start_i high and busy_o low.
//   busy_o stays high until the result is out; no new record is taken then.
//   Result channel: done_o is high for exactly one cycle with the result
//   fields valid; the receiver must take it then (no back-pressure).
//   Config: cfg_we_i writes cfg_wdata_i to register cfg_idx_i; the user must write
//   only while busy_o is low and no result is pending; the unit does not check.
// Timing:
//   The address table is searched one stored entry per cycle through one
//   shared comparator behind the registered read port of the address memory.
//   With N entries in use, a hit ends the search at its slot; a miss scans all
//   N entries and inserts at slot N. The counter memory slot is then read and
//   written back before done_o strobes. With the table full the record is
//   dropped and the result follows in the next cycle.
// Reset: clears the fill count, the sequencer and the config registers to
//   their defaults; table contents are not cleared (the contents of unwritten
//   slots are never used).
module per_source_event_flag_table_unit
  import psef_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned COUNT_BITS  = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // command
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [ADDR_W-1:0]     source_addr_i,
  input  logic [PORT_W-1:0]     source_port_i,
  input  logic                  proto_is_tcp_i,
  input  logic [STATE_W-1:0]    conn_state_i,
  input  logic [BYTES_W-1:0]    byte_count_i,
  // result
  output logic                  done_o,
  output logic [OUTIDX_W-1:0]   entry_index_o,
  output logic                  was_inserted_o,
  output logic                  dropped_o,
  output logic [TOTAL_W-1:0]    login_total_o,
  output logic [TOTAL_W-1:0]    scan_total_o,
  output logic [TOTAL_W-1:0]    conn_total_o,
  output logic                  is_flagged_o,
  // config
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned IDX_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W      = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned SLOT_EXT_W = (IDX_W > OUTIDX_W) ? IDX_W : OUTIDX_W;
  localparam int unsigned CMP_W      = (COUNT_BITS > TOTAL_W) ? COUNT_BITS : TOTAL_W;
  localparam int unsigned ENTRY_W    = 3 * COUNT_BITS + 1;

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;
  localparam logic [1:0] ST_UPD  = 2'd3;

  // config registers
  logic [PORT_W-1:0]  login_port_min_q, scan_port_min_q;
  logic [BYTES_W-1:0] scan_bytes_min_q;
  logic [TOTAL_W-1:0] flag_threshold_q;

  // control state
  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] used_q, used_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic             cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0] cmp_idx_q;
  logic [IDX_W-1:0] slot_q, slot_d;
  logic             ins_q, ins_d;
  logic             done_q, done_d;

  // latched record
  logic [ADDR_W-1:0]  addr_q;
  logic [PORT_W-1:0]  port_q;
  logic               tcp_q;
  logic [STATE_W-1:0] cstate_q;
  logic [BYTES_W-1:0] bytes_q;

  // memories and their read registers
  logic [ADDR_W-1:0]  addr_mem [TABLE_DEPTH];
  logic [ENTRY_W-1:0] cnt_mem  [TABLE_DEPTH];
  logic [ADDR_W-1:0]  addr_rd_q;
  logic [ENTRY_W-1:0] cnt_rd_q;

  // result registers
  logic [OUTIDX_W-1:0] res_idx_q;
  logic                res_ins_q, res_drop_q, res_flag_q;
  logic [TOTAL_W-1:0]  res_login_q, res_scan_q, res_conn_q;

  logic accept, full, issue, match;

  assign accept = start_i && (state_q == ST_IDLE);
  assign full   = (used_q == CNT_W'(TABLE_DEPTH));
  assign issue  = (idx_q != used_q);
  assign match  = cmp_vld_q && (addr_rd_q == addr_q);

  // Sequencer next state
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    cmp_vld_d = 1'b0;
    slot_d    = slot_q;
    ins_d     = ins_q;
    used_d    = used_q;
    done_d    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (full) begin
            done_d = 1'b1;
          end else begin
            state_d = ST_SCAN;
            idx_d   = '0;
          end
        end
      end
      ST_SCAN: begin
        if (match) begin
          slot_d  = cmp_idx_q;
          ins_d   = 1'b0;
          state_d = ST_READ;
        end else if (!issue) begin
          slot_d  = used_q[IDX_W-1:0];
          ins_d   = 1'b1;
          state_d = ST_READ;
        end else begin
          idx_d     = idx_q + 1'b1;
          cmp_vld_d = 1'b1;
        end
      end
      ST_READ: begin
        state_d = ST_UPD;
      end
      ST_UPD: begin
        if (ins_q) begin
          used_d = used_q + 1'b1;
        end
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Counter update for the selected slot
  logic [COUNT_BITS-1:0] login_old, scan_old, conn_old;
  logic [COUNT_BITS-1:0] login_new, scan_new, conn_new;
  logic                  flag_old, flag_new;
  logic                  hit_login, hit_scan, hit_conn;
  logic [CMP_W-1:0]      login_ext, scan_ext, conn_ext, thr_ext;

  always_comb begin
    if (ins_q) begin
      {flag_old, conn_old, scan_old, login_old} = '0;
    end else begin
      {flag_old, conn_old, scan_old, login_old} = cnt_rd_q;
    end
    hit_conn  = (cstate_q == CONN_RESET) || (cstate_q == CONN_INTERRUPTED);
    hit_scan  = tcp_q && (port_q > scan_port_min_q) && (bytes_q > scan_bytes_min_q);
    hit_login = (cstate_q == CONN_ESTABLISHED) && (port_q > login_port_min_q);
    conn_new  = (hit_conn && (conn_old != '1)) ? conn_old + 1'b1 : conn_old;
    scan_new  = (hit_scan && (scan_old != '1)) ? scan_old + 1'b1 : scan_old;
    login_new = (hit_login && (login_old != '1)) ? login_old + 1'b1 : login_old;
    login_ext = CMP_W'(login_new);
    scan_ext  = CMP_W'(scan_new);
    conn_ext  = CMP_W'(conn_new);
    thr_ext   = CMP_W'(flag_threshold_q);
    flag_new  = flag_old || (login_ext > thr_ext) || (scan_ext > thr_ext) ||
                (conn_ext > thr_ext);
  end

  logic [SLOT_EXT_W-1:0] slot_ext;
  assign slot_ext = SLOT_EXT_W'(slot_q);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      used_q    <= '0;
      idx_q     <= '0;
      cmp_vld_q <= 1'b0;
      slot_q    <= '0;
      ins_q     <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      used_q    <= used_d;
      idx_q     <= idx_d;
      cmp_vld_q <= cmp_vld_d;
      slot_q    <= slot_d;
      ins_q     <= ins_d;
      done_q    <= done_d;
    end
  end

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      login_port_min_q <= RST_LOGIN_PORT_MIN;
      scan_port_min_q  <= RST_SCAN_PORT_MIN;
      scan_bytes_min_q <= RST_SCAN_BYTES_MIN;
      flag_threshold_q <= RST_FLAG_THRESHOLD;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LOGIN_PORT_MIN: login_port_min_q <= cfg_wdata_i[PORT_W-1:0];
        CFG_SCAN_PORT_MIN:  scan_port_min_q  <= cfg_wdata_i[PORT_W-1:0];
        CFG_SCAN_BYTES_MIN: scan_bytes_min_q <= cfg_wdata_i[BYTES_W-1:0];
        CFG_FLAG_THRESHOLD: flag_threshold_q <= cfg_wdata_i[TOTAL_W-1:0];
        default: ;
      endcase
    end
  end

  // Record latch and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q   <= source_addr_i;
      port_q   <= source_port_i;
      tcp_q    <= proto_is_tcp_i;
      cstate_q <= conn_state_i;
      bytes_q  <= byte_count_i;
    end
    if (state_q == ST_SCAN) begin
      cmp_idx_q <= idx_q[IDX_W-1:0];
    end
    if (accept && full) begin
      res_idx_q   <= '0;
      res_ins_q   <= 1'b0;
      res_drop_q  <= 1'b1;
      res_login_q <= '0;
      res_scan_q  <= '0;
      res_conn_q  <= '0;
      res_flag_q  <= 1'b0;
    end else if (state_q == ST_UPD) begin
      res_idx_q   <= slot_ext[OUTIDX_W-1:0];
      res_ins_q   <= ins_q;
      res_drop_q  <= 1'b0;
      res_login_q <= login_ext[TOTAL_W-1:0];
      res_scan_q  <= scan_ext[TOTAL_W-1:0];
      res_conn_q  <= conn_ext[TOTAL_W-1:0];
      res_flag_q  <= flag_new;
    end
  end

  // Address memory: one read per scan cycle, written on insert
  always_ff @(posedge clk_i) begin
    if (state_q == ST_SCAN) begin
      addr_rd_q <= addr_mem[idx_q[IDX_W-1:0]];
    end
    if ((state_q == ST_UPD) && ins_q) begin
      addr_mem[slot_q] <= addr_q;
    end
  end

  // Counter memory: read the slot, then write the updated entry
  always_ff @(posedge clk_i) begin
    if (state_q == ST_READ) begin
      cnt_rd_q <= cnt_mem[slot_q];
    end
    if (state_q == ST_UPD) begin
      cnt_mem[slot_q] <= {flag_new, conn_new, scan_new, login_new};
    end
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign done_o         = done_q;
  assign entry_index_o  = res_idx_q;
  assign was_inserted_o = res_ins_q;
  assign dropped_o      = res_drop_q;
  assign login_total_o  = res_login_q;
  assign scan_total_o   = res_scan_q;
  assign conn_total_o   = res_conn_q;
  assign is_flagged_o   = res_flag_q;

`ifndef ASSERT_OFF
  // fill count never runs past the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CNT_W'(TABLE_DEPTH))
    else $error("fill count exceeds table depth");

  // a result only appears once the sequencer is back in idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while busy");

  // a record taken with a full table is dropped on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && full) |=> (done_o && dropped_o))
    else $error("full table did not drop record");

  // the fill count grows only with an inserted result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_q != $past(used_q)) |-> (done_o && was_inserted_o))
    else $error("fill count changed without insert");
`endif

endmodule

// ----- test/per_source_event_flag_table_unit_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for per_source_event_flag_table_unit.
// Drives flow records and register writes, predicts each result with a scoreboard
// class and compares every result field. Depends on psef_pkg and the unit.
module per_source_event_flag_table_unit_test;
  import psef_pkg::*;

  localparam int unsigned TABLE_SIZE = 64;
  localparam int unsigned RAND_PER_PHASE = 320;
  localparam int unsigned POOL_SIZE = 44;
  localparam logic [STATE_W-1:0] CONN_OTHER = 2'd3;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [PORT_W-1:0]  port;
    logic               tcp;
    logic [STATE_W-1:0] state;
    logic [BYTES_W-1:0] bytes;
  } flow_rec_t;

  typedef struct packed {
    logic [OUTIDX_W-1:0] index;
    logic                inserted;
    logic                dropped;
    logic [TOTAL_W-1:0]  login;
    logic [TOTAL_W-1:0]  scan;
    logic [TOTAL_W-1:0]  conn;
    logic                flagged;
  } flow_result_t;

  // Predicts the source table and holds the results still owed by the unit
  class source_table_model;
    logic [PORT_W-1:0]  login_min;
    logic [PORT_W-1:0]  scan_min;
    logic [BYTES_W-1:0] bytes_min;
    logic [TOTAL_W-1:0] thresh;
    logic [ADDR_W-1:0]  addrs[TABLE_SIZE];
    logic [TOTAL_W-1:0] logins[TABLE_SIZE];
    logic [TOTAL_W-1:0] scans[TABLE_SIZE];
    logic [TOTAL_W-1:0] conns[TABLE_SIZE];
    bit                 flags[TABLE_SIZE];
    int unsigned        used;
    int unsigned        errors;
    flow_result_t       owed[$];

    function new();
      login_min = RST_LOGIN_PORT_MIN;
      scan_min  = RST_SCAN_PORT_MIN;
      bytes_min = RST_SCAN_BYTES_MIN;
      thresh    = RST_FLAG_THRESHOLD;
      used      = 0;
      errors    = 0;
    endfunction

    function logic [TOTAL_W-1:0] bump(logic [TOTAL_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
    endfunction

    // Accepted record: update the table and queue the result it must produce
    function void note_record(flow_rec_t r);
      flow_result_t res;
      int unsigned slot;
      bit found;
      res = '0;
      if (used >= TABLE_SIZE) begin
        // table full: record ignored
        res.dropped = 1'b1;
        owed.push_back(res);
        return;
      end
      slot = 0;
      found = 1'b0;
      for (int unsigned i = 0; i < used; i++) begin
        if (!found && addrs[i] == r.addr) begin
          slot = i;
          found = 1'b1;
        end
      end
      if (!found) begin
        slot = used;
        addrs[slot] = r.addr;
        logins[slot] = '0;
        scans[slot] = '0;
        conns[slot] = '0;
        flags[slot] = 1'b0;
        used++;
        res.inserted = 1'b1;
      end
      if (r.state == CONN_RESET || r.state == CONN_INTERRUPTED)
        conns[slot] = bump(conns[slot]);
      if (r.tcp && r.port > scan_min && r.bytes > bytes_min)
        scans[slot] = bump(scans[slot]);
      if (r.state == CONN_ESTABLISHED && r.port > login_min)
        logins[slot] = bump(logins[slot]);
      if (logins[slot] > thresh || scans[slot] > thresh || conns[slot] > thresh)
        flags[slot] = 1'b1;
      res.index   = slot[OUTIDX_W-1:0];
      res.login   = logins[slot];
      res.scan    = scans[slot];
      res.conn    = conns[slot];
      res.flagged = flags[slot];
      owed.push_back(res);
    endfunction

    function bit compare(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        return 1'b1;
      end
      return 1'b0;
    endfunction

    // Result strobe: compare against the oldest owed result
    function void check_result(flow_result_t got);
      flow_result_t want;
      bit bad;
      if (owed.size() == 0) begin
        $error("result with no transaction outstanding: index %0d", got.index);
        errors++;
        return;
      end
      want = owed.pop_front();
      bad = 1'b0;
      bad |= compare("entry_index", want.index, got.index);
      bad |= compare("was_inserted", want.inserted, got.inserted);
      bad |= compare("dropped", want.dropped, got.dropped);
      bad |= compare("login_total", want.login, got.login);
      bad |= compare("scan_total", want.scan, got.scan);
      bad |= compare("conn_total", want.conn, got.conn);
      bad |= compare("is_flagged", want.flagged, got.flagged);
      if (bad) errors++;
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start_i;
  logic                  busy_o;
  logic [ADDR_W-1:0]     source_addr_i;
  logic [PORT_W-1:0]     source_port_i;
  logic                  proto_is_tcp_i;
  logic [STATE_W-1:0]    conn_state_i;
  logic [BYTES_W-1:0]    byte_count_i;
  logic                  done_o;
  logic [OUTIDX_W-1:0]   entry_index_o;
  logic                  was_inserted_o;
  logic                  dropped_o;
  logic [TOTAL_W-1:0]    login_total_o;
  logic [TOTAL_W-1:0]    scan_total_o;
  logic [TOTAL_W-1:0]    conn_total_o;
  logic                  is_flagged_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  source_table_model sb;
  bit quiet;                      // no idling while set
  bit seen_addr[logic [ADDR_W-1:0]];
  logic [ADDR_W-1:0] addr_pool[$];

  per_source_event_flag_table_unit #(
    .TABLE_DEPTH(TABLE_SIZE),
    .COUNT_BITS (16)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .source_addr_i (source_addr_i),
    .source_port_i (source_port_i),
    .proto_is_tcp_i(proto_is_tcp_i),
    .conn_state_i  (conn_state_i),
    .byte_count_i  (byte_count_i),
    .done_o        (done_o),
    .entry_index_o (entry_index_o),
    .was_inserted_o(was_inserted_o),
    .dropped_o     (dropped_o),
    .login_total_o (login_total_o),
    .scan_total_o  (scan_total_o),
    .conn_total_o  (conn_total_o),
    .is_flagged_o  (is_flagged_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    #10ms;
    $display("Simulation FAILED");
    $finish;
  end

  // Monitor: results first, then the accepted transaction
  always @(posedge clk_i) begin
    flow_rec_t rec;
    flow_result_t res;
    if (rst_ni) begin
      if (done_o) begin
        res.index    = entry_index_o;
        res.inserted = was_inserted_o;
        res.dropped  = dropped_o;
        res.login    = login_total_o;
        res.scan     = scan_total_o;
        res.conn     = conn_total_o;
        res.flagged  = is_flagged_o;
        sb.check_result(res);
      end
      if (start_i && !busy_o) begin
        rec.addr  = source_addr_i;
        rec.port  = source_port_i;
        rec.tcp   = proto_is_tcp_i;
        rec.state = conn_state_i;
        rec.bytes = byte_count_i;
        sb.note_record(rec);
      end
    end
  end

  function automatic flow_rec_t mk(logic [ADDR_W-1:0] a, logic [PORT_W-1:0] p, logic t,
                                   logic [STATE_W-1:0] s, logic [BYTES_W-1:0] b);
    flow_rec_t r;
    r.addr = a;
    r.port = p;
    r.tcp = t;
    r.state = s;
    r.bytes = b;
    seen_addr[a] = 1'b1;
    return r;
  endfunction

  // Random record for a given source; ports and byte counts cluster near the limits
  function automatic flow_rec_t random_record(logic [ADDR_W-1:0] a);
    flow_rec_t r;
    r.addr = a;
    r.tcp = 1'($urandom_range(0, 1));
    r.state = STATE_W'($urandom_range(0, 3));
    case ($urandom_range(0, 3))
      0: r.port = PORT_W'($urandom());
      1: r.port = sb.login_min + PORT_W'($urandom_range(0, 2)) - 1'b1;
      2: r.port = sb.scan_min + PORT_W'($urandom_range(0, 2)) - 1'b1;
      default: r.port = PORT_W'($urandom_range(60000, 65535));
    endcase
    case ($urandom_range(0, 2))
      0: r.bytes = $urandom();
      1: r.bytes = sb.bytes_min + BYTES_W'($urandom_range(0, 2)) - 1'b1;
      default: r.bytes = BYTES_W'($urandom_range(0, 20000));
    endcase
    return r;
  endfunction

  // Drive one transaction; entered and left at a falling edge
  task automatic send_record(input flow_rec_t r);
    if (!quiet && $urandom_range(0, 1) == 1) begin
      // let the unit go idle before the gap
      start_i <= 1'b0;
      do @(posedge clk_i); while (busy_o);
      @(negedge clk_i);
    end
    while (!quiet && $urandom_range(0, 99) < 34) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    source_addr_i  <= r.addr;
    source_port_i  <= r.port;
    proto_is_tcp_i <= r.tcp;
    conn_state_i   <= r.state;
    byte_count_i   <= r.bytes;
    start_i        <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
  endtask

  // Stop sending and wait for every owed result
  task automatic wait_drained();
    start_i <= 1'b0;
    do @(posedge clk_i); while (sb.owed.size() != 0);
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Write all four registers on consecutive edges; upper bits of 16-bit ones are junk
  task automatic apply_settings(input logic [PORT_W-1:0] login_min,
                                input logic [PORT_W-1:0] scan_min,
                                input logic [BYTES_W-1:0] bytes_min,
                                input logic [TOTAL_W-1:0] thresh);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_LOGIN_PORT_MIN;
    cfg_wdata_i <= {16'($urandom()), login_min};
    @(negedge clk_i);
    cfg_idx_i <= CFG_SCAN_PORT_MIN;
    cfg_wdata_i <= {16'($urandom()), scan_min};
    @(negedge clk_i);
    cfg_idx_i <= CFG_SCAN_BYTES_MIN;
    cfg_wdata_i <= bytes_min;
    @(negedge clk_i);
    cfg_idx_i <= CFG_FLAG_THRESHOLD;
    cfg_wdata_i <= {16'($urandom()), thresh};
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.login_min = login_min;
    sb.scan_min = scan_min;
    sb.bytes_min = bytes_min;
    sb.thresh = thresh;
  endtask

  // Main sequence
  initial begin
    logic [ADDR_W-1:0] a;
    sb = new();
    rst_ni = 1'b0;
    start_i = 1'b0;
    source_addr_i = '0;
    source_port_i = '0;
    proto_is_tcp_i = 1'b0;
    conn_state_i = '0;
    byte_count_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    quiet = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part at reset settings: field extremes, flag build-up, limit edges
    send_record(mk(32'h0, 16'h0, 1'b0, CONN_OTHER, 32'h0));
    send_record(mk(32'hFFFF_FFFF, 16'hFFFF, 1'b1, CONN_ESTABLISHED, 32'hFFFF_FFFF));
    send_record(mk(32'hFFFF_FFFF, 16'hFFFF, 1'b1, CONN_ESTABLISHED, 32'hFFFF_FFFF));
    send_record(mk(32'hFFFF_FFFF, 16'hFFFF, 1'b1, CONN_ESTABLISHED, 32'hFFFF_FFFF));
    send_record(mk(32'hFFFF_FFFF, 16'h0, 1'b0, CONN_OTHER, 32'h0));
    send_record(mk(32'h0, 16'h0, 1'b0, CONN_RESET, 32'h0));
    send_record(mk(32'h0, 16'h0, 1'b0, CONN_INTERRUPTED, 32'h0));
    send_record(mk(32'h0, 16'h0, 1'b0, CONN_RESET, 32'h0));
    send_record(mk(32'h0, 16'hFFFF, 1'b1, CONN_OTHER, 32'h0));
    send_record(mk(32'hAAAA_AAAA, 16'd10000, 1'b0, CONN_ESTABLISHED, 32'h0));
    send_record(mk(32'hAAAA_AAAA, 16'd10001, 1'b0, CONN_ESTABLISHED, 32'h0));
    send_record(mk(32'hAAAA_AAAA, 16'd10001, 1'b1, CONN_RESET, 32'd5));
    send_record(mk(32'h5555_5555, 16'd1024, 1'b1, CONN_OTHER, 32'd10001));
    send_record(mk(32'h5555_5555, 16'd1025, 1'b1, CONN_OTHER, 32'd10000));
    send_record(mk(32'h5555_5555, 16'd1025, 1'b1, CONN_OTHER, 32'd10001));
    send_record(mk(32'h5555_5555, 16'hFFFF, 1'b0, CONN_INTERRUPTED, 32'hFFFF_FFFF));
    send_record(mk(32'h8000_0000, 16'hAAAA, 1'b1, CONN_ESTABLISHED, 32'h5555_5555));
    send_record(mk(32'h0000_0001, 16'h5555, 1'b0, CONN_RESET, 32'hAAAA_AAAA));

    // Pool of distinct sources that the random part keeps revisiting
    while (addr_pool.size() < POOL_SIZE) begin
      a = $urandom();
      if (!seen_addr.exists(a)) begin
        seen_addr[a] = 1'b1;
        addr_pool.push_back(a);
      end
    end

    // Random phases, each under its own register settings
    for (int phase = 0; phase < 6; phase++) begin
      if (phase > 0) begin
        wait_drained();
        case (phase)
          1: apply_settings('0, '0, '0, '0);
          2: apply_settings('1, '1, '1, '1);
          3: apply_settings(PORT_W'($urandom()), PORT_W'($urandom()),
                            BYTES_W'($urandom_range(0, 50000)),
                            TOTAL_W'($urandom_range(1, 6)));
          4: apply_settings(16'd10000, 16'd1024, 32'd10000, 16'd2);
          default: apply_settings(PORT_W'($urandom()), PORT_W'($urandom()), $urandom(),
                                  TOTAL_W'($urandom_range(0, 8)));
        endcase
      end
      quiet = (phase == 3);
      repeat (RAND_PER_PHASE)
        send_record(random_record(addr_pool[$urandom_range(0, POOL_SIZE - 1)]));
    end
    quiet = 1'b0;

    // Fill the remaining slots with new sources
    while (sb.used < TABLE_SIZE) begin
      a = $urandom();
      if (!seen_addr.exists(a)) begin
        seen_addr[a] = 1'b1;
        send_record(random_record(a));
      end
    end

    // Table full: known and unknown sources are both dropped
    repeat (30) begin
      if ($urandom_range(0, 1) == 1) send_record(random_record(addr_pool[$urandom_range(0, POOL_SIZE - 1)]));
      else send_record(random_record($urandom()));
    end

    wait_drained();
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
